// File: rtl/ffsa_pkg.sv
`default_nettype none
package ffsa_pkg;

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_INFO  = 2'd2,
    CMD_CLEAR = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_NOFIT = 2'd1,
    ST_FULL  = 2'd2,
    ST_NOTAG = 2'd3
  } status_t;

  localparam logic REG_POOL_BASE = 1'b0;
  localparam logic REG_POOL_SIZE = 1'b1;

  typedef struct packed {
    logic [31:0] start;
    logic [31:0] length;
    logic        taken;
    logic [31:0] owner;
  } seg_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_LATCH,
    OP_SCAN_RD,
    OP_NEXT,
    OP_TAKE,
    OP_FIND,
    OP_SH_RD,
    OP_SH_WR,
    OP_SPLIT_HI,
    OP_SPLIT_LO,
    OP_FREE,
    OP_CMP_RD,
    OP_CMP_EV,
    OP_CMP_FIN,
    OP_CLEAR,
    OP_FAIL,
    OP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t  op;
    status_t code;
  } dp_ctl_t;

  typedef struct packed {
    cmd_t cmd;
    logic scan_end;
    logic too_big;
    logic alloc_match;
    logic free_match;
    logic exact;
    logic full;
    logic shift_done;
  } dp_sts_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SH_RD,
    S_SH_WR,
    S_SPLIT_LO,
    S_CMP_RD,
    S_CMP_EV,
    S_CLEAR,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

// File: rtl/ffsa_ctrl.sv
`default_nettype none
module ffsa_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       cmd,
  input  wire ffsa_pkg::dp_sts_t sts,
  output ffsa_pkg::dp_ctl_t     ctl,
  output logic                  busy
);
  import ffsa_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl.op     = OP_NONE;
    ctl.code   = ST_OK;
    busy       = (state != S_IDLE);
    unique case (state)
      S_IDLE: begin
        if (start) begin
          ctl.op = OP_LATCH;
          unique case (cmd_t'(cmd))
            CMD_ALLOC, CMD_FREE: state_next = S_SCAN_RD;
            CMD_INFO:            state_next = S_RESP;
            default:             state_next = S_CLEAR;
          endcase
        end
      end
      S_SCAN_RD: begin
        if (sts.scan_end || (sts.cmd == CMD_ALLOC && sts.too_big)) begin
          ctl.op     = OP_FAIL;
          ctl.code   = (sts.cmd == CMD_ALLOC) ? ST_NOFIT : ST_NOTAG;
          state_next = S_RESP;
        end else begin
          ctl.op     = OP_SCAN_RD;
          state_next = S_SCAN_EV;
        end
      end
      S_SCAN_EV: begin
        if (sts.cmd == CMD_ALLOC && sts.alloc_match) begin
          if (sts.exact) begin
            ctl.op     = OP_TAKE;
            state_next = S_RESP;
          end else if (sts.full) begin
            ctl.op     = OP_FAIL;
            ctl.code   = ST_FULL;
            state_next = S_RESP;
          end else begin
            ctl.op     = OP_FIND;
            state_next = S_SH_RD;
          end
        end else if (sts.cmd == CMD_FREE && sts.free_match) begin
          ctl.op     = OP_FREE;
          state_next = S_CMP_RD;
        end else begin
          ctl.op     = OP_NEXT;
          state_next = S_SCAN_RD;
        end
      end
      S_SH_RD: begin
        if (sts.shift_done) begin
          ctl.op     = OP_SPLIT_HI;
          state_next = S_SPLIT_LO;
        end else begin
          ctl.op     = OP_SH_RD;
          state_next = S_SH_WR;
        end
      end
      S_SH_WR: begin
        ctl.op     = OP_SH_WR;
        state_next = S_SH_RD;
      end
      S_SPLIT_LO: begin
        ctl.op     = OP_SPLIT_LO;
        state_next = S_RESP;
      end
      S_CMP_RD: begin
        if (sts.scan_end) begin
          ctl.op     = OP_CMP_FIN;
          state_next = S_RESP;
        end else begin
          ctl.op     = OP_CMP_RD;
          state_next = S_CMP_EV;
        end
      end
      S_CMP_EV: begin
        ctl.op     = OP_CMP_EV;
        state_next = S_CMP_RD;
      end
      S_CLEAR: begin
        ctl.op     = OP_CLEAR;
        state_next = S_RESP;
      end
      S_RESP: begin
        ctl.op     = OP_RESP;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/ffsa_dp.sv
`default_nettype none
module ffsa_dp #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ALIGN_SHIFT  = 12
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              cfg_we,
  input  wire logic              cfg_index,
  input  wire logic [31:0]       cfg_data,
  input  wire logic [1:0]        cmd,
  input  wire logic [31:0]       req_size,
  input  wire logic [31:0]       tag,
  input  wire ffsa_pkg::dp_ctl_t ctl,
  output ffsa_pkg::dp_sts_t      sts,
  output logic                   done,
  output logic [1:0]             status,
  output logic [31:0]            block_addr,
  output logic [31:0]            block_size,
  output logic [31:0]            used_total
);
  import ffsa_pkg::*;

  localparam int IW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
  localparam int CW = $clog2(MAX_SEGMENTS + 1);
  localparam logic [32:0] AMASK = (33'd1 << ALIGN_SHIFT) - 33'd1;

  seg_t seg_mem [MAX_SEGMENTS];
  seg_t rdata, wdata, fent, cur, ev;
  logic [IW-1:0] raddr, waddr, fidx;
  logic          we, have;
  logic [CW-1:0] idx, k, j, cnt, k_m1;
  logic [32:0]   sz, want;
  cmd_t          cmd_q;
  logic [31:0]   tag_q, used, pool_base, pool_size;
  logic [31:0]   res_addr, res_size, astart, pad, clr_len;
  status_t       res_status;

  // table memory, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      seg_mem[waddr] <= wdata;
    end
    rdata <= seg_mem[raddr];
  end

  assign want    = ({1'b0, req_size} + AMASK) & ~AMASK;
  assign astart  = pool_base + AMASK[31:0] & ~AMASK[31:0];
  assign pad     = astart - pool_base;
  assign clr_len = (pad <= pool_size) ? pool_size - pad : 32'd0;
  assign k_m1    = k - 1'b1;

  // compaction view: the released entry reads as free
  always_comb begin
    ev = rdata;
    if (idx[IW-1:0] - 1'b1 == fidx) begin
      ev.taken = 1'b0;
    end
  end

  always_comb begin
    sts.cmd         = cmd_q;
    sts.scan_end    = (idx == cnt);
    sts.too_big     = sz[32];
    sts.alloc_match = !rdata.taken && (rdata.length >= sz[31:0]);
    sts.free_match  = rdata.taken && (rdata.owner == tag_q);
    sts.exact       = (rdata.length == sz[31:0]);
    sts.full        = (cnt == CW'(MAX_SEGMENTS));
    sts.shift_done  = (k == CW'(fidx) + 1'b1);
  end

  always_comb begin
    raddr = idx[IW-1:0];
    waddr = idx[IW-1:0];
    wdata = rdata;
    we    = 1'b0;
    case (ctl.op)
      OP_SH_RD: raddr = k_m1[IW-1:0];
      OP_TAKE: begin
        we    = 1'b1;
        wdata = '{start: rdata.start, length: rdata.length, taken: 1'b1, owner: tag_q};
      end
      OP_SH_WR: begin
        we    = 1'b1;
        waddr = k[IW-1:0];
      end
      OP_SPLIT_HI: begin
        we    = 1'b1;
        waddr = fidx + 1'b1;
        wdata = '{start: fent.start + sz[31:0], length: fent.length - sz[31:0],
                  taken: 1'b0, owner: 32'd0};
      end
      OP_SPLIT_LO: begin
        we    = 1'b1;
        waddr = fidx;
        wdata = '{start: fent.start, length: sz[31:0], taken: 1'b1, owner: tag_q};
      end
      OP_CMP_EV: begin
        we    = have && !(!cur.taken && !ev.taken);
        waddr = j[IW-1:0];
        wdata = cur;
      end
      OP_CMP_FIN: begin
        we    = 1'b1;
        waddr = j[IW-1:0];
        wdata = cur;
      end
      OP_CLEAR: begin
        we    = 1'b1;
        waddr = '0;
        wdata = '{start: astart, length: clr_len, taken: 1'b0, owner: 32'd0};
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_base <= 32'd0;
      pool_size <= 32'd0;
      cnt       <= '0;
      used      <= 32'd0;
      done      <= 1'b0;
    end else begin
      done <= (ctl.op == OP_RESP);
      if (cfg_we) begin
        if (cfg_index == REG_POOL_BASE) pool_base <= cfg_data;
        else                            pool_size <= cfg_data;
      end
      case (ctl.op)
        OP_TAKE:     used <= used + sz[31:0];
        OP_SPLIT_LO: begin
          used <= used + sz[31:0];
          cnt  <= cnt + 1'b1;
        end
        OP_FREE:     used <= used - rdata.length;
        OP_CMP_FIN:  cnt  <= j + 1'b1;
        OP_CLEAR: begin
          used <= 32'd0;
          cnt  <= CW'(1);
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (ctl.op)
      OP_LATCH: begin
        cmd_q      <= cmd_t'(cmd);
        tag_q      <= tag;
        sz         <= want;
        idx        <= '0;
        res_status <= ST_OK;
        res_addr   <= 32'd0;
        res_size   <= 32'd0;
      end
      OP_NEXT: idx <= idx + 1'b1;
      OP_TAKE: begin
        res_addr <= rdata.start;
        res_size <= sz[31:0];
      end
      OP_FIND: begin
        fidx <= idx[IW-1:0];
        fent <= rdata;
        k    <= cnt;
      end
      OP_SH_WR: k <= k_m1;
      OP_SPLIT_LO: begin
        res_addr <= fent.start;
        res_size <= sz[31:0];
      end
      OP_FREE: begin
        fidx <= idx[IW-1:0];
        idx  <= '0;
        j    <= '0;
        have <= 1'b0;
      end
      OP_CMP_RD: idx <= idx + 1'b1;
      OP_CMP_EV: begin
        have <= 1'b1;
        if (!have) begin
          cur <= ev;
        end else if (!cur.taken && !ev.taken) begin
          cur.length <= cur.length + ev.length;
        end else begin
          j   <= j + 1'b1;
          cur <= ev;
        end
      end
      OP_FAIL: res_status <= ctl.code;
      OP_RESP: begin
        status     <= res_status;
        block_addr <= res_addr;
        block_size <= res_size;
        used_total <= used;
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

// File: rtl/first_fit_segment_allocator.sv
`default_nettype none
// First-fit segment allocator for one memory pool.
// Command channel: a transaction is taken on a clock edge with start high
// and busy low; cmd selects allocate, free by tag, info or clear, with
// req_size and tag as operands. Every transaction gives exactly one result
// on status/block_addr/block_size/used_total, valid for the one cycle that
// done is high. The receiver cannot stall; results are never held.
// Configuration: cfg_we writes cfg_data to pool_base (index 0) or
// pool_size (index 1); write only while busy is low.
// Steps: the segment table sits in a single memory with a registered read,
// so each entry visited takes a read state and an evaluate state. Info goes
// straight to the response, clear writes one entry first. Allocate scans to
// the hit and, on a split, shifts the entries above it up by one. Free
// searches for the tag and then runs a merge pass over the whole table.
// Reset: the table is empty (allocate reports no fit, free reports an
// unknown tag) until a clear command builds the pool segment. No memory
// clearing pass is needed; only entries below the count are read.
module first_fit_segment_allocator #(
  parameter int MAX_SEGMENTS = 16,
  parameter int ALIGN_SHIFT  = 12
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  input  wire logic        start,
  input  wire logic [1:0]  cmd,
  input  wire logic [31:0] req_size,
  input  wire logic [31:0] tag,
  output logic             busy,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      block_addr,
  output logic [31:0]      block_size,
  output logic [31:0]      used_total
);
  import ffsa_pkg::*;

  dp_ctl_t ctl;
  dp_sts_t sts;

  // sequencer: scan, shift, split and merge steps
  ffsa_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .cmd   (cmd),
    .sts   (sts),
    .ctl   (ctl),
    .busy  (busy)
  );

  // table memory, counters and result registers
  ffsa_dp #(
    .MAX_SEGMENTS (MAX_SEGMENTS),
    .ALIGN_SHIFT  (ALIGN_SHIFT)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .cmd        (cmd),
    .req_size   (req_size),
    .tag        (tag),
    .ctl        (ctl),
    .sts        (sts),
    .done       (done),
    .status     (status),
    .block_addr (block_addr),
    .block_size (block_size),
    .used_total (used_total)
  );

endmodule
`default_nettype wire

// File: rtl/ffsa_chk.sv
`default_nettype none
module ffsa_chk (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [31:0] block_addr,
  input wire logic [31:0] block_size
);
  import ffsa_pkg::*;

  // a result only appears once the block is free again
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("done while busy");

  // every accepted transaction occupies the block
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted transaction did not raise busy");

  // one result per transaction, never two in a row
  a_single_done: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("back to back done");

  // failed results carry no block
  a_fail_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (block_addr == 32'd0 && block_size == 32'd0))
    else $error("failed result carries a block");

endmodule

bind first_fit_segment_allocator ffsa_chk u_ffsa_chk (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .block_addr (block_addr),
  .block_size (block_size)
);
`default_nettype wire

// File: dv/tb.sv
`default_nettype none
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import ffsa_pkg::*;

  localparam int NSEG  = 16;
  localparam int ASH   = 12;
  localparam int PAGE  = 1 << ASH;
  localparam int WATCHDOG_LIMIT = 20000;
  localparam int SETTLE_CYCLES  = 100;

  typedef struct packed {
    status_t     status;
    logic [31:0] addr;
    logic [31:0] size;
    logic [31:0] used;
  } result_t;

  typedef struct {
    cmd_t        c;
    logic [31:0] req;
    logic [31:0] tg;
    bit          known;
    result_t     r;
  } stim_row_t;

  logic        clk, rst;
  logic        cfg_we, cfg_index;
  logic [31:0] cfg_data;
  logic        start;
  cmd_t        cmd;
  logic [31:0] req_size, tag;
  logic        busy, done;
  logic [1:0]  status;
  logic [31:0] block_addr, block_size, used_total;

  first_fit_segment_allocator #(.MAX_SEGMENTS(NSEG), .ALIGN_SHIFT(ASH)) dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data, .start, .cmd, .req_size, .tag,
    .busy, .done, .status, .block_addr, .block_size, .used_total
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Shadow of the segment table and pool registers
  logic [31:0] pool_base_q, pool_size_q;
  logic [31:0] tbl_start [NSEG];
  logic [31:0] tbl_len   [NSEG];
  logic        tbl_taken [NSEG];
  logic [31:0] tbl_owner [NSEG];
  int          tbl_count;
  logic [31:0] bytes_used;

  result_t     pending_results[$];
  int          errors = 0;
  int          idle_mode = 0;  // 0 none, 1 sender idles 80%, 2 sender 26%
  int          stall_cycles = 0;
  logic [31:0] tag_set[8];

  // Applies one command to the shadow table, returns what the block must report.
  function automatic result_t predict_allocator(cmd_t c, logic [31:0] req,
                                                logic [31:0] tg);
    result_t     r;
    logic [32:0] want;
    logic [31:0] sz, al, pad;
    int          i, j, k;
    bit          hit;
    r = '{ST_OK, 32'd0, 32'd0, 32'd0};
    case (c)
      CMD_ALLOC: begin
        want = ({1'b0, req} + 33'(PAGE - 1)) & ~33'(PAGE - 1);
        sz = want[31:0];
        hit = 1'b0;
        if (!want[32]) begin
          for (i = 0; i < tbl_count; i++)
            if (!tbl_taken[i] && tbl_len[i] >= sz) begin
              hit = 1'b1;
              break;
            end
        end
        if (!hit) begin
          r.status = ST_NOFIT;
        end else if (tbl_len[i] > sz && tbl_count >= NSEG) begin
          r.status = ST_FULL;
        end else begin
          if (tbl_len[i] > sz) begin
            // split: open a hole above the hit, remainder stays free
            for (k = tbl_count; k > i; k--) begin
              tbl_start[k] = tbl_start[k-1];
              tbl_len[k]   = tbl_len[k-1];
              tbl_taken[k] = tbl_taken[k-1];
              tbl_owner[k] = tbl_owner[k-1];
            end
            tbl_count++;
            tbl_start[i+1] = tbl_start[i] + sz;
            tbl_len[i+1]   = tbl_len[i] - sz;
            tbl_taken[i+1] = 1'b0;
            tbl_owner[i+1] = '0;
            tbl_len[i]     = sz;
          end
          tbl_taken[i] = 1'b1;
          tbl_owner[i] = tg;
          bytes_used += sz;
          r.addr = tbl_start[i];
          r.size = sz;
        end
      end
      CMD_FREE: begin
        hit = 1'b0;
        for (i = 0; i < tbl_count; i++)
          if (tbl_taken[i] && tbl_owner[i] == tg) begin
            hit = 1'b1;
            break;
          end
        if (!hit) begin
          r.status = ST_NOTAG;
        end else begin
          tbl_taken[i] = 1'b0;
          bytes_used -= tbl_len[i];
          // coalesce runs of free segments
          j = 0;
          for (i = 1; i < tbl_count; i++) begin
            if (!tbl_taken[j] && !tbl_taken[i]) begin
              tbl_len[j] += tbl_len[i];
            end else begin
              j++;
              tbl_start[j] = tbl_start[i];
              tbl_len[j]   = tbl_len[i];
              tbl_taken[j] = tbl_taken[i];
              tbl_owner[j] = tbl_owner[i];
            end
          end
          tbl_count = j + 1;
        end
      end
      CMD_CLEAR: begin
        al  = (pool_base_q + 32'(PAGE - 1)) & ~32'(PAGE - 1);  // wraps mod 2^32
        pad = al - pool_base_q;
        tbl_start[0] = al;
        tbl_len[0]   = (pad <= pool_size_q) ? pool_size_q - pad : 32'd0;
        tbl_taken[0] = 1'b0;
        tbl_owner[0] = '0;
        tbl_count    = 1;
        bytes_used   = '0;
      end
      default: ;
    endcase
    r.used = bytes_used;
    return r;
  endfunction

  // Launch one transaction; start stays high into the next one when no gap falls.
  task automatic send(cmd_t c, logic [31:0] req, logic [31:0] tg, bit known,
                      result_t typed);
    int      pct;
    result_t p;
    pct = (idle_mode == 1) ? 80 : (idle_mode == 2) ? 26 : 0;
    if (pct != 0 && $urandom_range(99) < pct) begin
      start <= 1'b0;
      while ($urandom_range(99) < pct) @(posedge clk);
      @(posedge clk);
    end
    start    <= 1'b1;
    cmd      <= c;
    req_size <= req;
    tag      <= tg;
    do @(posedge clk); while (busy);
    p = predict_allocator(c, req, tg);
    pending_results.push_back(known ? typed : p);
  endtask

  // Pause the sender until every result is back, then let the block settle.
  task automatic drain();
    start <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic idx, logic [31:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_POOL_BASE) pool_base_q = val;
    else pool_size_q = val;
  endtask

  // Result checker: done marks a one-cycle result that cannot be held off
  always @(posedge clk) begin
    result_t e;
    if (!rst && done) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result status=%0d addr=%h size=%h used=%h",
                 $realtime, status, block_addr, block_size, used_total);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (status !== e.status) begin
          $display("%0t: status expected %0d actual %0d", $realtime, e.status, status);
          errors++;
        end
        if (block_addr !== e.addr) begin
          $display("%0t: block_addr expected %h actual %h", $realtime, e.addr, block_addr);
          errors++;
        end
        if (block_size !== e.size) begin
          $display("%0t: block_size expected %h actual %h", $realtime, e.size, block_size);
          errors++;
        end
        if (used_total !== e.used) begin
          $display("%0t: used_total expected %h actual %h", $realtime, e.used, used_total);
          errors++;
        end
      end
    end
  end

  // Watchdog: cycles with no accepted transaction on either side
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  function automatic result_t mk(status_t s, logic [31:0] a, logic [31:0] z,
                                 logic [31:0] u);
    return '{s, a, z, u};
  endfunction

  function automatic logic [31:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 5) return 32'd0;
    if (r < 12) return $urandom;  // full-width, mostly no fit
    if (r < 20) return 32'h1 << $urandom_range(31);
    return $urandom_range(1, 6 * PAGE);
  endfunction

  stim_row_t dir_rows[$];

  task automatic add_row(cmd_t c, logic [31:0] req, logic [31:0] tg, bit known,
                         result_t r);
    stim_row_t s;
    s = '{c, req, tg, known, r};
    dir_rows.push_back(s);
  endtask

  initial begin
    int      n, r;
    result_t none;
    cmd_t    c;
    none      = mk(ST_OK, 0, 0, 0);
    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = 1'b0;
    cfg_data  = '0;
    start     = 1'b0;
    cmd       = CMD_INFO;
    req_size  = '0;
    tag       = '0;
    pool_base_q = '0;
    pool_size_q = '0;
    tbl_count   = 0;
    bytes_used  = '0;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty table, then a small unaligned pool of 7 pages (6 usable after alignment)
    add_row(CMD_ALLOC, 32'd100, 32'd1, 1, mk(ST_NOFIT, 0, 0, 0));
    add_row(CMD_FREE,  32'd0,   32'd1, 1, mk(ST_NOTAG, 0, 0, 0));
    add_row(CMD_INFO,  32'd0,   32'd0, 1, mk(ST_OK, 0, 0, 0));
    add_row(CMD_CLEAR, 32'd0,   32'd0, 1, mk(ST_OK, 0, 0, 0));
    add_row(CMD_ALLOC, 32'hFFFF_FFFF, 32'd5, 1, mk(ST_NOFIT, 0, 0, 0));
    add_row(CMD_ALLOC, 32'hFFFF_F000, 32'd5, 1, mk(ST_NOFIT, 0, 0, 0));
    add_row(CMD_ALLOC, 32'd0,   32'd0,          0, none);  // zero length, split
    add_row(CMD_ALLOC, 32'd1,   32'hFFFF_FFFF,  0, none);
    add_row(CMD_ALLOC, 32'd4097, 32'hA5A5_5A5A, 0, none);
    add_row(CMD_FREE,  32'd0,   32'h1234_5678,  1, mk(ST_NOTAG, 0, 0, 32'h0000_3000));
    add_row(CMD_FREE,  32'd0,   32'hFFFF_FFFF,  0, none);
    add_row(CMD_ALLOC, 32'd4096, 32'd7, 0, none);       // reuses the freed hole exactly
    add_row(CMD_FREE,  32'd0,   32'd0, 0, none);         // tag zero matches
    add_row(CMD_FREE,  32'd0,   32'd0, 0, none);         // now gone
    add_row(CMD_ALLOC, 32'd8192, 32'd8, 0, none);        // fits at the tail, splitting it
    add_row(CMD_ALLOC, 32'd1,   32'd9, 0, none);
    add_row(CMD_INFO,  32'hDEAD_BEEF, 32'hFFFF_FFFF, 0, none);
    add_row(CMD_FREE,  32'd0,   32'hA5A5_5A5A, 0, none);
    add_row(CMD_FREE,  32'd0,   32'd7, 0, none);
    add_row(CMD_CLEAR, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, mk(ST_OK, 0, 0, 0));
    for (int i = 0; i < 17; i++)  // one-page splits until the pool is used up
      add_row(CMD_ALLOC, 32'd1, i, 0, none);

    write_reg(REG_POOL_BASE, 32'h0000_1234);
    write_reg(REG_POOL_SIZE, 32'h0000_7000);
    foreach (dir_rows[i])
      send(dir_rows[i].c, dir_rows[i].req, dir_rows[i].tg, dir_rows[i].known,
           dir_rows[i].r);

    // Random phases: each pool setting paired with an idling pattern
    for (int ph = 0; ph < 8; ph++) begin
      drain();
      idle_mode = ph % 3;
      case (ph)
        0: begin write_reg(REG_POOL_BASE, 32'h0); write_reg(REG_POOL_SIZE, 32'h0); end
        1: begin  // base wraps to zero on alignment
          write_reg(REG_POOL_BASE, 32'hFFFF_FFFF);
          write_reg(REG_POOL_SIZE, 32'hFFFF_FFFF);
        end
        2: begin  // padding exceeds pool
          write_reg(REG_POOL_BASE, 32'h0000_1001);
          write_reg(REG_POOL_SIZE, 32'h0000_0800);
        end
        3: begin write_reg(REG_POOL_BASE, 32'h0); write_reg(REG_POOL_SIZE, 32'hFFFF_FFFF); end
        default: begin
          write_reg(REG_POOL_BASE, $urandom);
          write_reg(REG_POOL_SIZE, $urandom_range(8, 64) * PAGE + $urandom_range(PAGE - 1));
        end
      endcase
      tag_set[0] = 32'd0;
      tag_set[1] = 32'hFFFF_FFFF;
      for (int i = 2; i < 8; i++) tag_set[i] = $urandom;
      send(CMD_CLEAR, $urandom, $urandom, 0, none);
      n = (ph < 4) ? 100 : 180;
      for (int i = 0; i < n; i++) begin
        r = $urandom_range(99);
        c = (r < 48) ? CMD_ALLOC : (r < 88) ? CMD_FREE : (r < 97) ? CMD_INFO : CMD_CLEAR;
        send(c, pick_size(),
             ($urandom_range(9) == 0) ? $urandom : tag_set[$urandom_range(7)], 0, none);
      end
    end

    drain();
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: sim.f
rtl/ffsa_pkg.sv
rtl/ffsa_ctrl.sv
rtl/ffsa_dp.sv
rtl/first_fit_segment_allocator.sv
rtl/ffsa_chk.sv
dv/tb.sv
